// ----- hdl/fup_pkg.sv -----
// fup_pkg: shared types and constants of the frame update pacer
// used by fup_cell, fup_div, frame_update_pacer and fup_checker; no dependencies
`timescale 1ns / 1ps

package fup_pkg;

  localparam int TIME_W  = 31;
  localparam int GRANT_W = 2;
  localparam int UPS_W   = 10;
  localparam int RATE_W  = 16;
  localparam int SEC_W   = 22;
  localparam int SLOW_W  = 8;

  // rate divider: 31-bit dividend, 20-bit divisor (span below one million)
  localparam int DIV_DW = 31;
  localparam int DIV_VW = 20;

  // elapsed seconds: drop three bits (divide by 8), then multiply by 2^35 / 125
  // rounded up, exact for any 28-bit value
  localparam int SEC_PRE = 3;
  localparam int SEC_RW  = 29;
  localparam int SEC_SH  = 35;
  localparam int SEC_PW  = DIV_DW - SEC_PRE + SEC_RW;
  localparam logic [SEC_RW-1:0] SEC_RECIP = 29'd274877907;

  localparam logic [UPS_W-1:0] UPS_RESET = 10'd100;

  localparam logic signed [32:0] GAP_MAX     = 33'sd100000;
  localparam logic signed [32:0] SPAN_MAX    = 33'sd1000000;
  localparam logic signed [32:0] SLOW_LIMIT  = 33'sd25000;
  localparam logic signed [32:0] GRANT2_MIN  = 33'sd2000;
  localparam logic [31:0]        TOTAL_MAX   = 32'd255000;
  localparam logic [DIV_DW-1:0]  MS_PER_S    = 31'd1000;
  localparam logic [SEC_W-1:0]   SEC_SAT     = 22'h3FFFFF;
  localparam logic [RATE_W-1:0]  RATE_SAT    = 16'hFFFF;
  localparam logic [SLOW_W-1:0]  SLOW_SAT    = 8'hFF;
  localparam int                 PACE_MIN    = 8;

  localparam logic [GRANT_W-1:0] GRANT_ONE = 2'd1;
  localparam logic [GRANT_W-1:0] GRANT_TWO = 2'd2;

  typedef enum logic {
    REQ_FRAME = 1'b0,
    REQ_FLUSH = 1'b1
  } req_e;

  typedef struct packed {
    logic [TIME_W-1:0]  time_ms;
    logic [GRANT_W-1:0] grant;
  } entry_t;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

endpackage

// ----- hdl/fup_cell.sv -----
// fup_cell: one slot of the frame history chain (frame time and granted count)
// depends on fup_pkg for entry_t and cell_ctrl_t
`timescale 1ns / 1ps

module fup_cell (
  input  logic                clk_i,
  input  fup_pkg::cell_ctrl_t ctrl_i,
  input  fup_pkg::entry_t     neighbour_i,
  input  fup_pkg::entry_t     load_i,
  output fup_pkg::entry_t     entry_o
);
  import fup_pkg::*;

  entry_t entry_q, entry_d;

  // a direct load wins over the shift from the upper neighbour
  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.load) begin
      entry_d = load_i;
    end else if (ctrl_i.shift) begin
      entry_d = neighbour_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

// ----- hdl/fup_div.sv -----
// fup_div: restoring divider, one quotient bit per cycle
// depends on fup_pkg for the dividend and divisor widths
`timescale 1ns / 1ps

module fup_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [fup_pkg::DIV_DW-1:0]  dividend_i,
  input  logic [fup_pkg::DIV_VW-1:0]  divisor_i,
  output logic                        done_o,
  output logic [fup_pkg::DIV_DW-1:0]  quotient_o
);
  import fup_pkg::*;

  localparam int CW = $clog2(DIV_DW + 1);

  logic [DIV_DW-1:0] dvd_q, dvd_d;
  logic [DIV_VW-1:0] rem_q, rem_d;
  logic [DIV_VW-1:0] dsr_q;
  logic [CW-1:0]     cnt_q;
  logic              busy_q, done_q;
  logic [DIV_VW:0]   rem_sh;
  logic              q_bit;

  always_comb begin
    rem_sh = {rem_q, dvd_q[DIV_DW-1]};
    q_bit  = (rem_sh >= {1'b0, dsr_q});
    rem_d  = q_bit ? DIV_VW'(rem_sh - {1'b0, dsr_q}) : rem_sh[DIV_VW-1:0];
    dvd_d  = {dvd_q[DIV_DW-2:0], q_bit};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= !start_i && busy_q && (cnt_q == CW'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(DIV_DW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      dvd_q <= dvd_d;
      rem_q <= rem_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = dvd_q;

endmodule

// ----- hdl/frame_update_pacer.sv -----
// frame_update_pacer: top level, control sequencer, history chain and result register
// depends on fup_pkg, fup_cell and fup_div
`timescale 1ns / 1ps

// Frame update pacer. Every frame request carries a millisecond timestamp and
// returns one result: how many simulation updates to run (1 or 2), the measured
// update rate, the seconds since the window start, a count of successive slow
// windows and two flags for a time jump or a flushed window. A flush request
// clears the window and returns nothing. A frame request passes through the
// calc, multiply, divider wait and commit states to its result, and no new
// request is taken until it is done; the bit-serial divider for the update rate
// gives one quotient bit per cycle over 31 bits. Elapsed seconds come
// from a reciprocal multiplication in the cycle that starts the divider. The
// history is a chain of HISTORY_DEPTH cells that shifts by one when the window
// is full. There is no clearing pass after reset. A waiting result sits in its
// own register, so the next request is taken while the previous result is stalled.
module frame_update_pacer #(
  parameter int HISTORY_DEPTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [fup_pkg::UPS_W-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          req_type_i,
  input  logic [fup_pkg::TIME_W-1:0]    time_ms_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [fup_pkg::GRANT_W-1:0]   updates_to_run_o,
  output logic [fup_pkg::RATE_W-1:0]    measured_ups_o,
  output logic [fup_pkg::SEC_W-1:0]     elapsed_seconds_o,
  output logic [fup_pkg::SLOW_W-1:0]    slow_read_count_o,
  output logic                          time_jump_o,
  output logic                          window_flushed_o
);
  import fup_pkg::*;

  localparam int FW = $clog2(HISTORY_DEPTH + 1);
  localparam int TW = $clog2(2 * HISTORY_DEPTH + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_MUL,
    ST_UPS_WAIT,
    ST_COMMIT
  } state_e;

  state_e state_q;

  // window state
  logic [UPS_W-1:0]  ups_cfg_q;
  logic [FW-1:0]     held_q;
  logic [TW-1:0]     total_q;
  logic [TIME_W-1:0] wstart_q;
  logic [SLOW_W-1:0] slow_q;
  logic [RATE_W-1:0] rate_q;
  logic [SEC_W-1:0]  sec_q;
  logic [TIME_W-1:0] last_q;

  // per-request working registers
  logic [TIME_W-1:0] t_q;
  logic              full_q, first_q, jump_q, secupd_q, pace_q, ok_q;
  logic [FW-1:0]     held_new_q;
  logic [TW-1:0]     tot_q;
  logic [DIV_VW-1:0] span_q;
  logic [DIV_DW-1:0] el_q;
  logic signed [32:0] delta_q;
  logic [DIV_DW-1:0] secq_q;

  // result register
  logic              out_valid_q;
  logic [GRANT_W-1:0] o_grant_q;
  logic [RATE_W-1:0]  o_rate_q;
  logic [SEC_W-1:0]   o_sec_q;
  logic [SLOW_W-1:0]  o_slow_q;
  logic               o_jump_q, o_flush_q;

  // history chain
  entry_t     cell_out [HISTORY_DEPTH];
  cell_ctrl_t cell_ctrl [HISTORY_DEPTH];
  entry_t     load_entry;

  // divider
  logic              div_start, div_done;
  logic [DIV_DW-1:0] div_dividend, div_quot;
  logic [DIV_VW-1:0] div_divisor;

  // calc stage logic
  logic               full_c;
  logic [FW-1:0]      held_new_c;
  logic signed [32:0] gap_c, span_c, el_c;
  logic               jump_c;
  logic [TW-1:0]      tot_c;
  logic [TIME_W-1:0]  oldest_c;

  // commit logic
  logic               commit;
  logic [GRANT_W-1:0] grant_c;
  logic [FW-1:0]      load_idx;
  logic [DIV_DW-1:0]  tk_c;
  logic [SEC_PW-1:0]  sec_prod;

  assign full_c     = (held_q == FW'(HISTORY_DEPTH));
  assign held_new_c = full_c ? held_q : held_q + FW'(1);
  assign oldest_c   = full_c ? cell_out[1].time_ms : cell_out[0].time_ms;
  assign gap_c      = $signed({2'b00, t_q}) - $signed({2'b00, last_q});
  assign span_c     = $signed({2'b00, t_q}) - $signed({2'b00, oldest_c});
  assign el_c       = $signed({2'b00, t_q}) - $signed({2'b00, wstart_q});
  assign jump_c     = (held_q != '0) && ((gap_c < 0) || (gap_c > GAP_MAX));
  // running sum of the held grants: new entry counts 1, the dropped one leaves
  assign tot_c      = total_q + TW'(1) - (full_c ? TW'(cell_out[0].grant) : TW'(0));
  assign tk_c       = DIV_DW'(tot_q) * MS_PER_S;
  // milliseconds to seconds
  assign sec_prod   = SEC_PW'(el_q[DIV_DW-1:SEC_PRE]) * SEC_PW'(SEC_RECIP);

  assign commit  = (state_q == ST_COMMIT) && (!out_valid_q || !out_stall_i);
  assign grant_c = (!jump_q && pace_q && ok_q && (delta_q >= GRANT2_MIN)) ? GRANT_TWO
                                                                        : GRANT_ONE;

  assign div_start    = (state_q == ST_MUL);
  assign div_dividend = tk_c;
  assign div_divisor  = span_q;

  fup_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dividend),
    .divisor_i (div_divisor),
    .done_o    (div_done),
    .quotient_o(div_quot)
  );

  assign load_idx   = jump_q ? '0 : (full_q ? FW'(HISTORY_DEPTH - 1) : held_q);
  assign load_entry = '{time_ms: t_q, grant: grant_c};

  for (genvar i = 0; i < HISTORY_DEPTH; i++) begin : g_cell
    entry_t nb;
    assign cell_ctrl[i].load  = commit && (load_idx == FW'(i));
    assign cell_ctrl[i].shift = commit && !jump_q && full_q;
    if (i < HISTORY_DEPTH - 1) begin : g_mid
      assign nb = cell_out[i+1];
    end else begin : g_top
      assign nb = load_entry;
    end
    fup_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (cell_ctrl[i]),
      .neighbour_i(nb),
      .load_i     (load_entry),
      .entry_o    (cell_out[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ups_cfg_q   <= UPS_RESET;
      held_q      <= '0;
      total_q     <= '0;
      wstart_q    <= '0;
      slow_q      <= '0;
      rate_q      <= '0;
      sec_q       <= '0;
      out_valid_q <= 1'b0;
      o_grant_q   <= '0;
      o_rate_q    <= '0;
      o_sec_q     <= '0;
      o_slow_q    <= '0;
      o_jump_q    <= 1'b0;
      o_flush_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        ups_cfg_q <= cfg_data_i;
      end
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            if (req_type_i == REQ_FLUSH) begin
              held_q  <= '0;
              total_q <= '0;
              slow_q  <= '0;
              rate_q  <= '0;
              sec_q   <= '0;
            end else begin
              state_q <= ST_CALC;
            end
          end
        end
        ST_CALC:     state_q <= ST_MUL;
        ST_MUL:      state_q <= ST_UPS_WAIT;
        ST_UPS_WAIT: if (div_done) state_q <= ST_COMMIT;
        ST_COMMIT: begin
          if (commit) begin
            state_q     <= ST_IDLE;
            o_grant_q   <= grant_c;
            o_jump_q    <= jump_q;
            o_flush_q   <= 1'b0;
            if (jump_q) begin
              held_q   <= FW'(1);
              total_q  <= TW'(1);
              wstart_q <= t_q;
              slow_q   <= '0;
              rate_q   <= '0;
              sec_q    <= '0;
              o_slow_q <= '0;
              o_rate_q <= '0;
              o_sec_q  <= '0;
            end else if (pace_q && !ok_q) begin
              held_q    <= '0;
              total_q   <= '0;
              slow_q    <= '0;
              rate_q    <= '0;
              sec_q     <= '0;
              o_slow_q  <= '0;
              o_rate_q  <= '0;
              o_sec_q   <= '0;
              o_flush_q <= 1'b1;
            end else begin
              logic [SEC_W-1:0]  sec_n;
              logic [RATE_W-1:0] rate_n;
              logic [SLOW_W-1:0] slow_n;
              sec_n  = sec_q;
              rate_n = rate_q;
              slow_n = slow_q;
              if (secupd_q) begin
                sec_n = (secq_q > DIV_DW'(SEC_SAT)) ? SEC_SAT : secq_q[SEC_W-1:0];
              end
              if (pace_q) begin
                rate_n = (div_quot > DIV_DW'(RATE_SAT)) ? RATE_SAT : div_quot[RATE_W-1:0];
                if (delta_q > SLOW_LIMIT) begin
                  slow_n = (slow_q == SLOW_SAT) ? slow_q : slow_q + SLOW_W'(1);
                end else begin
                  slow_n = '0;
                end
              end
              if (first_q) begin
                wstart_q <= t_q;
              end
              held_q   <= held_new_q;
              total_q  <= tot_q + ((grant_c == GRANT_TWO) ? TW'(1) : TW'(0));
              sec_q    <= sec_n;
              rate_q   <= rate_n;
              slow_q   <= slow_n;
              o_sec_q  <= sec_n;
              o_rate_q <= rate_n;
              o_slow_q <= slow_n;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // per-request working registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) begin
      t_q <= time_ms_i;
    end
    if (state_q == ST_CALC) begin
      full_q     <= full_c;
      first_q    <= (held_q == '0);
      held_new_q <= held_new_c;
      jump_q     <= jump_c;
      secupd_q   <= (held_q != '0) && !jump_c;
      pace_q     <= !jump_c && (held_new_c > FW'(PACE_MIN));
      ok_q       <= (span_c > 0) && (span_c < SPAN_MAX) &&
                    (32'(tot_c) >= 32'(held_new_c)) && (32'(tot_c) < TOTAL_MAX);
      tot_q      <= tot_c;
      span_q     <= span_c[DIV_VW-1:0];
      el_q       <= (el_c < 0) ? '0 : el_c[DIV_DW-1:0];
    end
    if (state_q == ST_MUL) begin
      delta_q <= $signed({3'b000, 30'(span_q * ups_cfg_q)}) - $signed({2'b00, tk_c});
      secq_q  <= DIV_DW'(sec_prod[SEC_PW-1:SEC_SH]);
    end
    if (commit) begin
      last_q <= t_q;
    end
  end

  assign in_stall_o        = (state_q != ST_IDLE);
  assign out_valid_o       = out_valid_q;
  assign updates_to_run_o  = o_grant_q;
  assign measured_ups_o    = o_rate_q;
  assign elapsed_seconds_o = o_sec_q;
  assign slow_read_count_o = o_slow_q;
  assign time_jump_o       = o_jump_q;
  assign window_flushed_o  = o_flush_q;

endmodule

// ----- hdl/fup_checker.sv -----
// fup_checker: port-level assertions for frame_update_pacer, with its bind
// depends on fup_pkg for field widths and grant codes
`timescale 1ns / 1ps

module fup_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [fup_pkg::GRANT_W-1:0]   updates_to_run_o,
  input logic [fup_pkg::RATE_W-1:0]    measured_ups_o,
  input logic [fup_pkg::SEC_W-1:0]     elapsed_seconds_o,
  input logic [fup_pkg::SLOW_W-1:0]    slow_read_count_o,
  input logic                          time_jump_o,
  input logic                          window_flushed_o
);
  import fup_pkg::*;

  // a stalled result holds its grant, rate, seconds and slow count
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(updates_to_run_o) &&
    $stable(measured_ups_o) && $stable(elapsed_seconds_o) && $stable(slow_read_count_o))
    else $error("stalled result changed");

  a_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (updates_to_run_o == GRANT_ONE) || (updates_to_run_o == GRANT_TWO))
    else $error("grant out of range");

  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(time_jump_o && window_flushed_o))
    else $error("jump and flush together");

  // a restarted or flushed window reports cleared statistics and a single update
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (time_jump_o || window_flushed_o) |->
    (updates_to_run_o == GRANT_ONE) && (measured_ups_o == '0) &&
    (elapsed_seconds_o == '0) && (slow_read_count_o == '0))
    else $error("restart did not clear statistics");

endmodule

bind frame_update_pacer fup_checker u_fup_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .updates_to_run_o (updates_to_run_o),
  .measured_ups_o   (measured_ups_o),
  .elapsed_seconds_o(elapsed_seconds_o),
  .slow_read_count_o(slow_read_count_o),
  .time_jump_o      (time_jump_o),
  .window_flushed_o (window_flushed_o)
);
